// ===== hw/rtl/hsto_pkg.sv =====
// ----------------------------------------------------------------------------
// hsto_pkg: shared types and constants of the hashed segment timeout table
// Field widths, command and status codes, and the result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package hsto_pkg;

   // field widths
   localparam int KEY_W      = 32;
   localparam int LIMIT_W    = 16;
   localparam int ELAPSED_W  = 16;
   localparam int CMD_W      = 3;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 48;   // key, time_limit
   localparam int RSP_DATA_W = 64;   // found_key, found_limit, found_elapsed

   // scan reports at most this many entries
   localparam int MAX_RESULTS = 16;
   localparam int NCOUNT_W    = 5;

   // key hashing: sign bit dropped before the remainder
   localparam logic [KEY_W-1:0] KEY_MASK = 32'h7FFF_FFFF;

   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = 16'hFFFF;

   // command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SCAN   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

   // status codes
   localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL        = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NOT_PRESENT = 2'd2;

   // one result word
   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [KEY_W-1:0]  key;
      logic [LIMIT_W-1:0]       limit;
      logic [ELAPSED_W-1:0]     elapsed;
      logic                     last;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hsto_hash_unit.sv =====
// ----------------------------------------------------------------------------
// hsto_hash_unit: two-stage segment hash
// Computes (key AND 0x7FFFFFFF) mod SEGMENTS from constant residue tables:
// the byte residues are summed in the first stage and the sum is reduced in
// the second; done pulses when seg is valid, after start passes through sum_valid_ff and done_ff.
// ----------------------------------------------------------------------------
`default_nettype none

module hsto_hash_unit #(
   parameter int SEGMENTS = 16,
   localparam int SEG_W = $clog2(SEGMENTS)
) (
   input  wire                                    clock,
   input  wire                                    reset,
   input  wire                                    start,
   input  wire logic signed [hsto_pkg::KEY_W-1:0] key,
   output logic                                   done,
   output logic [SEG_W-1:0]                       seg
);
   import hsto_pkg::*;

   // weight of each key byte modulo SEGMENTS
   localparam int unsigned WEIGHT0 = 1;
   localparam int unsigned WEIGHT1 = 256 % SEGMENTS;
   localparam int unsigned WEIGHT2 = 65536 % SEGMENTS;
   localparam int unsigned WEIGHT3 = 16777216 % SEGMENTS;

   typedef logic [255:0][SEG_W-1:0] residue_tab_type;

   // residue of (byte * weight) for every byte value
   function automatic residue_tab_type build_tab(input int unsigned weight);
      residue_tab_type tab;
      for (int unsigned b = 0; b < 256; b++) begin
         tab[b] = SEG_W'((b * weight) % SEGMENTS);
      end
      return tab;
   endfunction

   localparam residue_tab_type TAB0 = build_tab(WEIGHT0);
   localparam residue_tab_type TAB1 = build_tab(WEIGHT1);
   localparam residue_tab_type TAB2 = build_tab(WEIGHT2);
   localparam residue_tab_type TAB3 = build_tab(WEIGHT3);

   logic [KEY_W-1:0] masked;
   logic [7:0]       sum_ff, sum_in;
   logic             sum_valid_ff;
   logic             done_ff;
   logic [SEG_W-1:0] seg_ff;

   assign masked = key & KEY_MASK;

   // byte residues summed: at most 4 * (SEGMENTS - 1), fits in a byte while SEGMENTS is at most 64
   assign sum_in = 8'(TAB0[masked[7:0]]) + 8'(TAB1[masked[15:8]]) +
                   8'(TAB2[masked[23:16]]) + 8'(TAB3[masked[31:24]]);

   // stage flags
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         sum_valid_ff <= start;
         done_ff      <= sum_valid_ff;
      end
   end

   // sum, then final reduction of the sum
   always_ff @(posedge clock) begin
      if (start) begin
         sum_ff <= sum_in;
      end
      if (sum_valid_ff) begin
         seg_ff <= TAB0[sum_ff];
      end
   end

   assign done = done_ff;
   assign seg  = seg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hashed_segment_timeout_table.sv =====
// ----------------------------------------------------------------------------
// hashed_segment_timeout_table: direct-mapped table of timed segments
// Insert, search, remove, tick, expiry scan and clear over SEGMENTS entries.
// ----------------------------------------------------------------------------
// Each request word carries a command; the block takes one word at a time and
// answers every command except the unused codes with one or more result words.
// Insert, search and remove first reduce the key to its entry in a two-stage
// residue unit; insert and remove then answer through ST_EMIT, and search
// first reads the entry in ST_SRD. Tick and scan walk the entry memory one
// entry per cycle through its single read port, a scan pausing while a found
// entry waits on an output register that the result side has not drained.
// Every command is held up while the result side stalls. A new word is
// taken as soon as the last result of the previous one is in the output
// register. Scan reports at most 16 expired entries in ascending order; the
// final result of each command has rsp_tlast set.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_segment_timeout_table #(
   parameter int SEGMENTS = 16
) (
   input  wire                                   clock,
   input  wire                                   reset,
   // request: tdata = key[31:0], time_limit[47:32]; tuser = command
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire [hsto_pkg::REQ_DATA_W-1:0]        req_tdata,
   input  wire [hsto_pkg::CMD_W-1:0]             req_tuser,
   // response: tdata = found_key[31:0], found_limit[47:32],
   //           found_elapsed[63:48]; tuser = status; tlast = last
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [hsto_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic [hsto_pkg::STATUS_W-1:0]         rsp_tuser,
   output logic                                  rsp_tlast
);
   import hsto_pkg::*;

   localparam int SEG_W = $clog2(SEGMENTS);
   localparam int CNT_W = $clog2(SEGMENTS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_HASH = 3'd1;
   localparam logic [2:0] ST_SRD  = 3'd2;
   localparam logic [2:0] ST_TICK = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_SFIN = 3'd5;
   localparam logic [2:0] ST_EMIT = 3'd6;

   localparam result_type RES_OK =
      '{status: STAT_OK, key: '0, limit: '0, elapsed: '0, last: 1'b1};

   // control state
   logic [2:0]          state_ff, state_in;
   logic [SEGMENTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                chk_en_ff, chk_en_in;
   logic [SEG_W-1:0]    chk_addr_ff, chk_addr_in;
   logic [NCOUNT_W-1:0] n_ff, n_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                rsp_valid_ff;

   // payload
   logic [CMD_W-1:0]        cmd_ff, cmd_in;
   logic signed [KEY_W-1:0] key_ff, key_in;
   logic [LIMIT_W-1:0]      lim_ff, lim_in;
   result_type              pend_ff, pend_in;
   result_type              out_ff;
   result_type              out_data;
   result_type              scan_res;

   // entry memory
   logic signed [KEY_W-1:0] key_mem [SEGMENTS];
   logic [LIMIT_W-1:0]      lim_mem [SEGMENTS];
   logic [ELAPSED_W-1:0]    el_mem  [SEGMENTS];
   logic signed [KEY_W-1:0] key_rd_ff;
   logic [LIMIT_W-1:0]      lim_rd_ff;
   logic [ELAPSED_W-1:0]    el_rd_ff;
   logic [SEG_W-1:0]        rd_addr;
   logic                    rd_en;
   logic [SEG_W-1:0]        wr_addr;
   logic                    kl_we;
   logic                    el_we;
   logic [ELAPSED_W-1:0]    el_wdata;
   logic [SEG_W-1:0]        idx_addr;

   logic                    req_accept;
   logic                    out_free;
   logic                    out_load;
   logic                    hit;
   logic                    hash_start;
   logic                    hash_done;
   logic [SEG_W-1:0]        hash_seg;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign idx_addr   = (idx_ff < CNT_W'(SEGMENTS)) ? idx_ff[SEG_W-1:0] : '0;

   // key hash
   hsto_hash_unit #(
      .SEGMENTS(SEGMENTS)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .key   ($signed(req_tdata[KEY_W-1:0])),
      .done  (hash_done),
      .seg   (hash_seg)
   );

   // expiry check on the entry read last cycle
   assign hit = chk_en_ff && valid_ff[chk_addr_ff] && (el_rd_ff >= lim_rd_ff) &&
                (n_ff < NCOUNT_W'(MAX_RESULTS));

   always_comb begin
      scan_res         = RES_OK;
      scan_res.key     = key_rd_ff;
      scan_res.limit   = lim_rd_ff;
      scan_res.elapsed = el_rd_ff;
      scan_res.last    = 1'b0;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      lim_in        = lim_ff;
      valid_in      = valid_ff;
      used_in       = used_ff;
      idx_in        = idx_ff;
      chk_en_in     = 1'b0;
      chk_addr_in   = chk_addr_ff;
      n_in          = n_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      out_load      = 1'b0;
      out_data      = pend_ff;
      hash_start    = 1'b0;
      rd_addr       = idx_addr;
      rd_en         = 1'b1;
      wr_addr       = hash_seg;
      kl_we         = 1'b0;
      el_we         = 1'b0;
      el_wdata      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = req_tuser;
               key_in = $signed(req_tdata[KEY_W-1:0]);
               lim_in = req_tdata[KEY_W +: LIMIT_W];
               case (req_tuser)
                  CMD_INSERT, CMD_SEARCH, CMD_REMOVE: begin
                     hash_start = 1'b1;
                     state_in   = ST_HASH;
                  end
                  CMD_TICK: begin
                     idx_in   = '0;
                     state_in = ST_TICK;
                  end
                  CMD_SCAN: begin
                     idx_in        = '0;
                     n_in          = '0;
                     pend_valid_in = 1'b0;
                     state_in      = ST_SCAN;
                  end
                  CMD_CLEAR: begin
                     valid_in = '0;
                     used_in  = '0;
                     pend_in  = RES_OK;
                     state_in = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_HASH: begin
            rd_addr = hash_seg;
            if (hash_done) begin
               pend_in  = RES_OK;
               state_in = ST_EMIT;
               case (cmd_ff)
                  CMD_INSERT: begin
                     if (used_ff == CNT_W'(SEGMENTS)) begin
                        pend_in.status = STAT_FULL;
                     end else begin
                        if (!valid_ff[hash_seg]) begin
                           used_in = used_ff + 1'b1;
                        end
                        valid_in[hash_seg] = 1'b1;
                        kl_we = 1'b1;
                        el_we = 1'b1;
                     end
                  end
                  CMD_SEARCH: begin
                     if (!valid_ff[hash_seg]) begin
                        pend_in.status = STAT_NOT_PRESENT;
                     end else begin
                        state_in = ST_SRD;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!valid_ff[hash_seg]) begin
                        pend_in.status = STAT_NOT_PRESENT;
                     end else begin
                        valid_in[hash_seg] = 1'b0;
                        used_in = used_ff - 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_SRD: begin
            pend_in         = RES_OK;
            pend_in.key     = key_rd_ff;
            pend_in.limit   = lim_rd_ff;
            pend_in.elapsed = el_rd_ff;
            state_in        = ST_EMIT;
         end
         ST_TICK: begin
            // write back the entry read last cycle, read the next one
            wr_addr  = chk_addr_ff;
            el_wdata = el_rd_ff + 1'b1;
            if (chk_en_ff && valid_ff[chk_addr_ff] && (el_rd_ff != ELAPSED_MAX)) begin
               el_we = 1'b1;
            end
            if (idx_ff == CNT_W'(SEGMENTS)) begin
               pend_in  = RES_OK;
               state_in = ST_EMIT;
            end else begin
               chk_en_in   = 1'b1;
               chk_addr_in = idx_ff[SEG_W-1:0];
               idx_in      = idx_ff + 1'b1;
            end
         end
         ST_SCAN: begin
            if (hit && pend_valid_ff && !out_free) begin
               // hold the walk until the output register drains
               rd_en     = 1'b0;
               chk_en_in = chk_en_ff;
            end else begin
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     out_data = pend_ff;
                  end
                  pend_in       = scan_res;
                  pend_valid_in = 1'b1;
                  n_in          = n_ff + 1'b1;
               end
               if (idx_ff == CNT_W'(SEGMENTS)) begin
                  state_in = ST_SFIN;
               end else begin
                  chk_en_in   = 1'b1;
                  chk_addr_in = idx_ff[SEG_W-1:0];
                  idx_in      = idx_ff + 1'b1;
               end
            end
         end
         ST_SFIN: begin
            if (pend_valid_ff) begin
               pend_in.last = 1'b1;
            end else begin
               pend_in        = RES_OK;
               pend_in.status = STAT_NOT_PRESENT;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load      = 1'b1;
               out_data      = pend_ff;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         used_ff       <= '0;
         idx_ff        <= '0;
         chk_en_ff     <= 1'b0;
         n_ff          <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         used_ff       <= used_in;
         idx_ff        <= idx_in;
         chk_en_ff     <= chk_en_in;
         n_ff          <= n_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      lim_ff      <= lim_in;
      chk_addr_ff <= chk_addr_in;
      pend_ff     <= pend_in;
   end

   // entry memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (kl_we) begin
         key_mem[wr_addr] <= key_ff;
         lim_mem[wr_addr] <= lim_ff;
      end
      if (el_we) begin
         el_mem[wr_addr] <= el_wdata;
      end
      if (rd_en) begin
         key_rd_ff <= key_mem[rd_addr];
         lim_rd_ff <= lim_mem[rd_addr];
         el_rd_ff  <= el_mem[rd_addr];
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ff <= out_data;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {out_ff.elapsed, out_ff.limit, out_ff.key};
   assign rsp_tuser  = out_ff.status;
   assign rsp_tlast  = out_ff.last;

   // checks
   a_used_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_ff) == int'(used_ff))
      else $error("used count differs from number of valid entries");

   a_load_only_when_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("output register overwritten while a word is waiting");

   a_pend_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> (state_ff == ST_SCAN || state_ff == ST_SFIN ||
                         state_ff == ST_EMIT))
      else $error("pending scan result outside of a scan");

   a_hash_done_in_hash: assert property (@(posedge clock) disable iff (reset)
      hash_done |-> state_ff == ST_HASH)
      else $error("hash finished outside of the hash state");

   a_scan_count_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= NCOUNT_W'(MAX_RESULTS))
      else $error("scan reported more entries than allowed");

endmodule

`default_nettype wire

// ===== bench/hashed_segment_timeout_table_test.sv =====
// ----------------------------------------------------------------------------
// hashed_segment_timeout_table_test: self-checking bench for the timeout table
// Streams commands into the table and checks every result word against a
// shadow copy of the table. A short directed pass opens the run, followed by
// a steady stretch with the response side always ready. Randomized fill,
// expiry and churn sequences close the run. The request side idles in
// bursts and the response side stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module hashed_segment_timeout_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   import hsto_pkg::*;

   localparam int SEGMENTS = 16;
   // codes the table ignores
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;
   localparam int RANDOM_WORDS = 230;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [KEY_W-1:0]   key;
      logic [LIMIT_W-1:0] limit;
      bit                 steady;   // no idling around this word
   } table_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // key, time_limit
   logic [CMD_W-1:0]      req_tuser = '0;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // found_key, found_limit, found_elapsed
   logic [STATUS_W-1:0]   rsp_tuser;        // status
   logic                  rsp_tlast;

   hashed_segment_timeout_table #(.SEGMENTS(SEGMENTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // pending stimulus and expected result words
   table_word_type command_queue[$];
   result_type     expected_results[$];
   table_word_type on_bus;
   logic           quiet = 1'b0;

   // shadow copy of the table
   logic                 shadow_valid   [SEGMENTS];
   logic [KEY_W-1:0]     shadow_key     [SEGMENTS];
   logic [LIMIT_W-1:0]   shadow_limit   [SEGMENTS];
   logic [ELAPSED_W-1:0] shadow_elapsed [SEGMENTS];
   int                   shadow_used = 0;

   int words_queued = 0;
   int words_accepted = 0;
   int words_checked = 0;
   int expiry_hits = 0;
   int full_rejects = 0;
   int fail_count = 0;

   initial begin
      for (int i = 0; i < SEGMENTS; i++) begin
         shadow_valid[i] = 1'b0;
      end
   end

   // work out the result words of one accepted command
   task automatic predict_table(input table_word_type w);
      result_type r;
      int unsigned s;
      int hits;
      s = (w.key & KEY_MASK) % SEGMENTS;
      r = '0;
      r.last = 1'b1;
      hits = 0;
      case (w.cmd)
         CMD_INSERT: begin
            if (shadow_used >= SEGMENTS) begin
               r.status = STAT_FULL;
               full_rejects++;
            end else begin
               if (!shadow_valid[s]) shadow_used++;
               shadow_valid[s]   = 1'b1;
               shadow_key[s]     = w.key;
               shadow_limit[s]   = w.limit;
               shadow_elapsed[s] = '0;
               r.status = STAT_OK;
            end
            expected_results.push_back(r);
         end
         CMD_SEARCH: begin
            if (shadow_valid[s]) begin
               r.status  = STAT_OK;
               r.key     = shadow_key[s];
               r.limit   = shadow_limit[s];
               r.elapsed = shadow_elapsed[s];
            end else begin
               r.status = STAT_NOT_PRESENT;
            end
            expected_results.push_back(r);
         end
         CMD_REMOVE: begin
            if (shadow_valid[s]) begin
               shadow_valid[s] = 1'b0;
               if (shadow_used > 0) shadow_used--;
               r.status = STAT_OK;
            end else begin
               r.status = STAT_NOT_PRESENT;
            end
            expected_results.push_back(r);
         end
         CMD_TICK: begin
            for (int i = 0; i < SEGMENTS; i++) begin
               if (shadow_valid[i] && shadow_elapsed[i] != ELAPSED_MAX)
                  shadow_elapsed[i] = shadow_elapsed[i] + 1'b1;
            end
            expected_results.push_back(r);
         end
         CMD_SCAN: begin
            // one word per expired entry (at most MAX_RESULTS), ascending, tlast on the final one; NOT_PRESENT if none
            for (int i = 0; i < SEGMENTS && hits < MAX_RESULTS; i++) begin
               if (shadow_valid[i] && shadow_elapsed[i] >= shadow_limit[i]) begin
                  if (hits > 0) expected_results.push_back(r);
                  r.status  = STAT_OK;
                  r.key     = shadow_key[i];
                  r.limit   = shadow_limit[i];
                  r.elapsed = shadow_elapsed[i];
                  r.last    = 1'b0;
                  hits++;
               end
            end
            if (hits == 0) r.status = STAT_NOT_PRESENT;
            r.last = 1'b1;
            expected_results.push_back(r);
            expiry_hits += hits;
         end
         CMD_CLEAR: begin
            for (int i = 0; i < SEGMENTS; i++) begin
               shadow_valid[i] = 1'b0;
            end
            shadow_used = 0;
            expected_results.push_back(r);
         end
         default: begin
            // spare codes: no result, no change
         end
      endcase
   endtask

   task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [KEY_W-1:0] key,
                             input logic [LIMIT_W-1:0] limit, input bit steady = 1'b0);
      table_word_type w;
      w.cmd = cmd;
      w.key = key;
      w.limit = limit;
      w.steady = steady;
      command_queue.push_back(w);
      if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B) words_queued++;
   endtask

   // random key that lands in segment s (16 segments select on the low bits)
   function automatic logic [KEY_W-1:0] key_for(input int s);
      logic [KEY_W-1:0] k;
      k = $urandom;
      k[3:0] = s[3:0];
      return k;
   endfunction

   // mostly short limits so entries expire within a few ticks
   function automatic logic [LIMIT_W-1:0] pick_limit();
      if ($urandom_range(0, 3) != 0) return LIMIT_W'($urandom_range(0, 8));
      return LIMIT_W'($urandom);
   endfunction

   task automatic note_mismatch(input string what, input result_type want,
                                input result_type got);
      fail_count++;
      if (fail_count <= 10)
         $display({"%0t %s: expected st=%0d key=%h lim=%h el=%h last=%b, ",
                   "got st=%0d key=%h lim=%h el=%h last=%b"},
                  $time, what, want.status, want.key, want.limit, want.elapsed,
                  want.last, got.status, got.key, got.limit, got.elapsed, got.last);
   endtask

   // request driver: bursts of words separated by random gaps
   int burst_left = 8;
   int gap_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_table(on_bus);
            words_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (command_queue.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (gap_left > 0 && !command_queue[0].steady) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               on_bus = command_queue.pop_front();
               req_tdata  <= {on_bus.limit, on_bus.key};
               req_tuser  <= on_bus.cmd;
               req_tvalid <= 1'b1;
               quiet      <= on_bus.steady;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
               end else begin
                  burst_left--;
               end
            end
         end
      end
   end

   // response monitor and stall pattern
   int stall_mode = 0;
   int mode_left = 0;
   int stall_left = 0;

   always @(posedge clock) begin : check_words
      result_type got;
      result_type want;
      logic ready_next;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.status  = rsp_tuser;
            got.key     = rsp_tdata[KEY_W-1:0];
            got.limit   = rsp_tdata[KEY_W +: LIMIT_W];
            got.elapsed = rsp_tdata[KEY_W+LIMIT_W +: ELAPSED_W];
            got.last    = rsp_tlast;
            words_checked++;
            if (expected_results.size() == 0) begin
               note_mismatch("unexpected word", '0, got);
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status || got.key !== want.key ||
                   got.limit !== want.limit || got.elapsed !== want.elapsed ||
                   got.last !== want.last)
                  note_mismatch("mismatch", want, got);
            end
         end
         // modes: always ready, random stalls, long stalls
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 200);
         end else begin
            mode_left--;
         end
         if (quiet) begin
            ready_next = 1'b1;
         end else begin
            case (stall_mode)
               0: ready_next = 1'b1;
               1: ready_next = ($urandom_range(0, 3) != 0);
               default: begin
                  if (stall_left > 0) begin
                     stall_left--;
                     ready_next = 1'b0;
                  end else if ($urandom_range(0, 7) == 0) begin
                     stall_left = $urandom_range(1, 8);
                     ready_next = 1'b0;
                  end else begin
                     ready_next = 1'b1;
                  end
               end
            endcase
         end
         rsp_tready <= ready_next;
      end
   end

   // stimulus, reset and end of run
   initial begin : stimulus
      int base;
      int pick;
      int n;
      bit fill_next;

      // directed: empty table, replacement, aliasing keys, spare codes
      queue_word(CMD_CLEAR, 32'h0000_0000, 16'h0000);
      queue_word(CMD_SEARCH, 32'h0000_0000, 16'h0000);
      queue_word(CMD_REMOVE, 32'hFFFF_FFFF, 16'hFFFF);
      queue_word(CMD_SCAN, 32'h0000_0000, 16'h0000);
      queue_word(CMD_TICK, 32'h0000_0000, 16'h0000);
      queue_word(CMD_INSERT, 32'h0000_0000, 16'h0000);
      queue_word(CMD_INSERT, 32'h8000_0000, 16'h0000);
      queue_word(CMD_INSERT, 32'h7FFF_FFFF, 16'hFFFF);
      queue_word(CMD_SEARCH, 32'h0000_0010, 16'h0000);
      queue_word(CMD_TICK, 32'hFFFF_FFFF, 16'hFFFF);
      queue_word(CMD_SCAN, 32'hFFFF_FFFF, 16'hFFFF);
      queue_word(CMD_REMOVE, 32'h0000_0020, 16'h0000);
      queue_word(CMD_SEARCH, 32'h0000_0000, 16'h0000);
      queue_word(CMD_SPARE_A, 32'hFFFF_FFFF, 16'hFFFF);
      queue_word(CMD_SPARE_B, 32'h0000_0000, 16'h0000);
      queue_word(CMD_INSERT, 32'h0000_0005, 16'h0001);
      queue_word(CMD_SCAN, 32'h0000_0000, 16'h0000);
      queue_word(CMD_SEARCH, 32'hFFFF_FFFF, 16'h0000);

      // steady stretch, back to back with the response side always ready
      queue_word(CMD_SCAN, 32'h0000_0000, 16'h0000, 1'b1);
      queue_word(CMD_TICK, 32'h0000_0000, 16'h0000, 1'b1);
      queue_word(CMD_SCAN, 32'h0000_0000, 16'h0000, 1'b1);
      queue_word(CMD_TICK, 32'h0000_0000, 16'h0000, 1'b1);
      queue_word(CMD_SEARCH, 32'h7FFF_FFFF, 16'h0000, 1'b1);
      queue_word(CMD_CLEAR, 32'h0000_0000, 16'h0000, 1'b1);

      // random sequences: table fills with expiry scans, and mixed churn
      n = words_queued + RANDOM_WORDS;
      fill_next = 1'b1;
      while (words_queued < n) begin
         if (fill_next || $urandom_range(0, 99) < 35) begin
            base = $urandom_range(0, SEGMENTS - 1);
            for (int i = 0; i < SEGMENTS; i++) begin
               queue_word(CMD_INSERT, key_for((base + i) % SEGMENTS),
                          LIMIT_W'($urandom_range(0, 6)));
            end
            for (int i = $urandom_range(1, 2); i > 0; i--) begin
               queue_word(CMD_INSERT, $urandom, pick_limit());
            end
            for (int i = $urandom_range(0, 6); i > 0; i--) begin
               queue_word(CMD_TICK, $urandom, $urandom);
            end
            queue_word(CMD_SCAN, $urandom, $urandom);
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
               queue_word(CMD_REMOVE, key_for($urandom_range(0, SEGMENTS - 1)), $urandom);
               queue_word(CMD_SEARCH, key_for($urandom_range(0, SEGMENTS - 1)), $urandom);
            end
            queue_word(CMD_TICK, $urandom, $urandom);
            queue_word(CMD_SCAN, $urandom, $urandom);
            if ($urandom_range(0, 1) == 0) queue_word(CMD_CLEAR, $urandom, $urandom);
         end else begin
            for (int i = $urandom_range(10, 30); i > 0; i--) begin
               pick = $urandom_range(0, 99);
               if (pick < 30)      queue_word(CMD_INSERT, $urandom, pick_limit());
               else if (pick < 45) queue_word(CMD_SEARCH, $urandom, $urandom);
               else if (pick < 57) queue_word(CMD_REMOVE, $urandom, $urandom);
               else if (pick < 77) queue_word(CMD_TICK, $urandom, $urandom);
               else if (pick < 92) queue_word(CMD_SCAN, $urandom, $urandom);
               else if (pick < 95) queue_word(CMD_CLEAR, $urandom, $urandom);
               else if (pick < 98) queue_word(CMD_SPARE_A, $urandom, $urandom);
               else                queue_word(CMD_SPARE_B, $urandom, $urandom);
            end
         end
         fill_next = 1'b0;
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // drain: every word taken, every result seen, then a settling margin
      while (command_queue.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SEGMENTS * 2 + 16) @(posedge clock);
      if (expected_results.size() != 0) fail_count++;

      $display("summary: %0d commands accepted, %0d result words checked",
               words_accepted, words_checked);
      $display("summary: %0d expired entries reported, %0d inserts rejected on a full table",
               expiry_hits, full_rejects);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("tb: failure");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d result words outstanding", expected_results.size());
      $display("tb: failure");
      $finish;
   end

endmodule
